FILE: design/bhxc_pkg.sv
// Shared types, constants and helpers for the nibble-swap XOR chain cipher.
// No dependencies; imported by every module of the block.
`default_nettype none

package bhxc_pkg;

  localparam int KEY_BYTES     = 16;
  localparam int KEY_LEN_W     = 5;
  localparam int KEY_POS_W     = 4;
  localparam int HDR_CNT_W     = 4;
  localparam int CFG_DATA_W    = 64;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_W   = 2;
  localparam int QUEUE_CNT_W   = 3;

  localparam logic [HDR_CNT_W-1:0] HEADER_LEN = 4'd8;
  localparam logic [KEY_LEN_W-1:0] KEY_MAX    = 5'd16;
  localparam logic [7:0]           CHAIN_INIT = 8'h36;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MODE     = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_KEY_HIGH = 2'd2,
    REG_KEY_LEN  = 2'd3
  } reg_index_t;

  localparam logic [1:0] MODE_STREAM_DEC = 2'd0;
  localparam logic [1:0] MODE_STREAM_ENC = 2'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_TYPE    = 2'd2;
  localparam logic [1:0] ST_OVERRUN = 2'd3;

  localparam logic [3:0] TYPE_PLAIN = 4'd0;
  localparam logic [3:0] TYPE_CHAIN = 4'd1;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,   // byte consumed, no result
    OP_BARE  = 2'd1,   // result with zero byte and an error status
    OP_PASS  = 2'd2,   // byte passed through unchanged
    OP_XFORM = 2'd3    // byte goes through the chain cipher
  } op_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_mark;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    op_kind_t   kind;
    logic       encrypt;
    logic       restart;
    logic       finish;
    logic [7:0] data_byte;
    logic [1:0] status;
  } op_t;

  function automatic logic [7:0] swap_nibbles(input logic [7:0] v);
    swap_nibbles = {v[3:0], v[7:4]};
  endfunction

endpackage

`default_nettype wire

FILE: design/bhxc_front.sv
// Front end: accepts input bytes, tracks the block header and classifies
// each byte into an op for the cipher back end. Depends on bhxc_pkg.
`default_nettype none

module bhxc_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [1:0]         mode,
  input  wire logic               byte_valid,
  input  wire bhxc_pkg::in_item_t byte_item,
  input  wire logic               queue_full,
  output logic                    push,
  output bhxc_pkg::op_t           op
);
  import bhxc_pkg::*;

  logic [HDR_CNT_W-1:0] header_count, header_count_next;
  logic [3:0]           encryption_type, encryption_type_next;
  logic [7:0]           encrypted_left, encrypted_left_next;
  logic [1:0]           block_error, block_error_next;

  logic [HDR_CNT_W-1:0] hc;
  logic [3:0]           et;
  logic [7:0]           el;
  logic [1:0]           berr;
  logic [1:0]           bare_st;

  assign push = byte_valid && !queue_full;

  always_comb begin
    hc   = byte_item.first ? '0 : header_count;
    et   = byte_item.first ? '0 : encryption_type;
    el   = byte_item.first ? '0 : encrypted_left;
    berr = byte_item.first ? '0 : block_error;

    header_count_next    = hc;
    encryption_type_next = et;
    encrypted_left_next  = el;
    block_error_next     = berr;
    bare_st              = ST_OK;

    op.kind      = OP_NONE;
    op.encrypt   = (mode == MODE_STREAM_ENC);
    op.restart   = byte_item.first;
    op.finish    = byte_item.last;
    op.data_byte = byte_item.data_byte;
    op.status    = ST_OK;

    if (!mode[1]) begin
      op.kind = OP_XFORM;
    end else if (hc < HEADER_LEN) begin
      header_count_next = hc + 4'd1;
      if (hc == 4'd0) begin
        encryption_type_next = byte_item.data_byte[7:4];
      end
      if (hc == 4'd1) begin
        encrypted_left_next = byte_item.data_byte;
      end
      if (header_count_next == HEADER_LEN && encryption_type_next > TYPE_CHAIN) begin
        block_error_next = ST_TYPE;
      end
      if (header_count_next < HEADER_LEN) begin
        bare_st = ST_SHORT;
      end else if (block_error_next != ST_OK) begin
        bare_st = block_error_next;
      end else if (encryption_type_next == TYPE_CHAIN && encrypted_left_next != 8'd0) begin
        bare_st = ST_OVERRUN;
      end
      if (byte_item.last && bare_st != ST_OK) begin
        op.kind   = OP_BARE;
        op.status = bare_st;
      end
    end else if (berr != ST_OK) begin
      if (byte_item.last) begin
        op.kind   = OP_BARE;
        op.status = berr;
      end
    end else begin
      op.encrypt = 1'b0;
      if (et == TYPE_CHAIN && el != 8'd0) begin
        op.kind             = OP_XFORM;
        encrypted_left_next = el - 8'd1;
      end else begin
        op.kind = OP_PASS;
      end
      if (byte_item.last && encrypted_left_next != 8'd0) begin
        op.status = ST_OVERRUN;
      end
    end

    // a final byte closes the unit
    if (byte_item.last) begin
      header_count_next    = '0;
      encryption_type_next = TYPE_PLAIN;
      encrypted_left_next  = '0;
      block_error_next     = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count    <= '0;
      encryption_type <= TYPE_PLAIN;
      encrypted_left  <= '0;
      block_error     <= ST_OK;
    end else if (push) begin
      header_count    <= header_count_next;
      encryption_type <= encryption_type_next;
      encrypted_left  <= encrypted_left_next;
      block_error     <= block_error_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/bhxc_queue.sv
// Short op queue between the front end and the cipher back end.
// Depends on bhxc_pkg for the op type and depth constants.
`default_nettype none

module bhxc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire bhxc_pkg::op_t push_op,
  input  wire logic          pop,
  output logic               full,
  output logic               nonempty,
  output bhxc_pkg::op_t      head_op
);
  import bhxc_pkg::*;

  op_t                    entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full     = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head_op  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/bhxc_back.sv
// Back end: runs the chain cipher on queued ops and holds the result register.
// Depends on bhxc_pkg.
`default_nettype none

module bhxc_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [63:0]                key_low,
  input  wire logic [63:0]                key_high,
  input  wire logic [bhxc_pkg::KEY_LEN_W-1:0] key_length,
  input  wire logic                       op_valid,
  input  wire bhxc_pkg::op_t              op,
  output logic                            pop,
  output logic                            result_valid,
  output bhxc_pkg::out_item_t             result_item,
  input  wire logic                       result_stall
);
  import bhxc_pkg::*;

  logic [7:0]           chain_byte, chain_byte_next;
  logic [7:0]           cipher_position, cipher_position_next;
  logic [KEY_POS_W-1:0] key_position, key_position_next;

  logic [7:0]           chain_cur;
  logic [7:0]           cpos_cur;
  logic [KEY_LEN_W-1:0] len;
  logic [KEY_LEN_W-1:0] kp;
  logic [KEY_LEN_W-1:0] kp_inc;
  logic [127:0]         key_vec;
  logic [7:0]           key_byte;
  logic [7:0]           raw;
  logic [7:0]           xform_byte;
  logic                 advance;
  logic                 emits;
  out_item_t            res;

  assign advance = !result_valid || !result_stall;
  assign pop     = op_valid && advance;
  assign emits   = (op.kind != OP_NONE);
  assign key_vec = {key_high, key_low};

  always_comb begin
    chain_cur = op.restart ? CHAIN_INIT : chain_byte;
    cpos_cur  = op.restart ? 8'd0 : cipher_position;
    len       = (key_length > KEY_MAX) ? KEY_MAX : key_length;
    kp        = op.restart ? '0 : {1'b0, key_position};
    // position beyond a shrunken key restarts the cycle
    if (kp >= len) begin
      kp = '0;
    end
    key_byte = key_vec[{kp[KEY_POS_W-1:0], 3'b000} +: 8];
    kp_inc   = kp + 5'd1;
    raw      = op.data_byte ^ chain_cur ^ cpos_cur ^ key_byte;

    chain_byte_next      = chain_cur;
    cipher_position_next = cpos_cur;
    key_position_next    = kp[KEY_POS_W-1:0];
    xform_byte           = op.data_byte;

    if (op.kind == OP_XFORM) begin
      cipher_position_next = cpos_cur + 8'd1;
      if (len != '0) begin
        if (op.encrypt) begin
          xform_byte      = swap_nibbles(raw);
          chain_byte_next = xform_byte;
        end else begin
          xform_byte      = swap_nibbles(op.data_byte) ^ chain_cur ^ cpos_cur ^ key_byte;
          chain_byte_next = op.data_byte;
        end
        key_position_next = (kp_inc >= len) ? '0 : kp_inc[KEY_POS_W-1:0];
      end else begin
        key_position_next = (op.restart ? '0 : key_position);
      end
    end else if (op.restart) begin
      key_position_next = '0;
    end else begin
      key_position_next = key_position;
    end

    if (op.finish) begin
      chain_byte_next      = CHAIN_INIT;
      cipher_position_next = 8'd0;
      key_position_next    = '0;
    end

    res.end_mark = op.finish;
    res.status   = op.status;
    unique case (op.kind)
      OP_BARE:  res.out_byte = 8'd0;
      OP_PASS:  res.out_byte = op.data_byte;
      OP_XFORM: res.out_byte = xform_byte;
      default:  res.out_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_byte      <= CHAIN_INIT;
      cipher_position <= '0;
      key_position    <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (pop) begin
        chain_byte      <= chain_byte_next;
        cipher_position <= cipher_position_next;
        key_position    <= key_position_next;
      end
      if (advance) begin
        result_valid <= pop && emits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emits) begin
      result_item <= res;
    end
  end

endmodule

`default_nettype wire

FILE: design/block_header_xor_chain_cipher_top.sv
// Top level of the nibble-swap XOR chain cipher: configuration registers,
// front end, op queue and cipher back end. Depends on bhxc_pkg.
//
// Usage:
//   Input channel byte_valid / byte_stall / byte_item carries one byte per
//   request with first and last marks; a request is taken when byte_valid is
//   high and byte_stall low. Result channel result_valid / result_stall /
//   result_item carries at most one result per input byte, in order.
//   A taken byte is written into the op queue, and its result is then
//   registered in the result register. Throughput: one byte per cycle while
//   the receiver does not stall the result channel.
//   Header and unsupported-type bytes give no result unless final and in error.
//   When the receiver stalls, the result register holds and the four-entry op
//   queue fills; byte_stall rises once the queue is full.
//   Reset (rst, synchronous) clears configuration to zero, empties the queue
//   and restarts the chain at 0x36. Configuration is written through
//   cfg_write / cfg_index / cfg_data while no byte is in flight.
`default_nettype none

module block_header_xor_chain_cipher_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [bhxc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              byte_valid,
  output logic                                   byte_stall,
  input  wire bhxc_pkg::in_item_t                byte_item,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output bhxc_pkg::out_item_t                    result_item
);
  import bhxc_pkg::*;

  logic [1:0]           mode;
  logic [63:0]          key_low;
  logic [63:0]          key_high;
  logic [KEY_LEN_W-1:0] key_length;

  logic push;
  logic pop;
  logic queue_full;
  logic queue_nonempty;
  op_t  push_op;
  op_t  head_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_STREAM_DEC;
      key_low    <= '0;
      key_high   <= '0;
      key_length <= '0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_MODE:     mode       <= cfg_data[1:0];
        REG_KEY_LOW:  key_low    <= cfg_data;
        REG_KEY_HIGH: key_high   <= cfg_data;
        REG_KEY_LEN:  key_length <= cfg_data[KEY_LEN_W-1:0];
        default:      mode       <= mode;
      endcase
    end
  end

  assign byte_stall = queue_full;

  bhxc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .byte_valid (byte_valid),
    .byte_item  (byte_item),
    .queue_full (queue_full),
    .push       (push),
    .op         (push_op)
  );

  bhxc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_op  (push_op),
    .pop      (pop),
    .full     (queue_full),
    .nonempty (queue_nonempty),
    .head_op  (head_op)
  );

  bhxc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .key_low      (key_low),
    .key_high     (key_high),
    .key_length   (key_length),
    .op_valid     (queue_nonempty),
    .op           (head_op),
    .pop          (pop),
    .result_valid (result_valid),
    .result_item  (result_item),
    .result_stall (result_stall)
  );

endmodule

`default_nettype wire

FILE: design/bhxc_checker.sv
// Port-level checks for the chain cipher top level, attached by bind.
// Depends on bhxc_pkg and block_header_xor_chain_cipher_top.
`default_nettype none

module bhxc_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                byte_stall,
  input wire logic                result_valid,
  input wire logic                result_stall,
  input wire bhxc_pkg::out_item_t result_item
);
  import bhxc_pkg::*;

  // a stalled result stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !result_valid && !byte_stall)
    else $error("outputs active right after reset");

  // every error status closes a unit
  a_error_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.status != ST_OK |-> result_item.end_mark)
    else $error("error status on a non-final result");

  a_bare_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_item.status == ST_SHORT || result_item.status == ST_TYPE)
      |-> result_item.out_byte == 8'd0)
    else $error("bare error result carries data");

endmodule

bind block_header_xor_chain_cipher_top bhxc_checker u_bhxc_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_stall   (byte_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_item  (result_item)
);

`default_nettype wire
